FILE: design/ridmtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ridmtf_pkg;

   // List geometry and counter limits
   localparam int ListDepth     = 5;
   localparam int IdWidth       = 32;
   localparam int CountWidth    = 10;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 2;

   localparam logic [CountWidth-1:0] CountMax     = CountWidth'(999);
   localparam logic [1:0]            CountingType = 2'd2;

   // Event kinds
   typedef enum logic [1:0] {
      KIND_WIN   = 2'd0,
      KIND_LOSS  = 2'd1,
      KIND_TRADE = 2'd2,
      KIND_UNDEF = 2'd3
   } kind_type;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrCardValid = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCardType  = 1'd1;

   typedef logic [IdWidth-1:0]    id_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef id_type [ListDepth-1:0] list_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic [IdWidth-1:0] partner_id;
   } req_type;

   typedef struct packed {
      logic      ignored;
      logic      id_was_new;
      count_type wins_total;
      count_type losses_total;
      count_type trades_total;
   } rsp_type;

   // Saturating increment of an event counter
   function automatic count_type sat_inc(input count_type value);
      count_type result;
      if (value >= CountMax) begin
         result = CountMax;
      end else begin
         result = value + count_type'(1);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: design/recent_id_move_to_front_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// A request passes from the input register into the result register once that one is
// free or its result is taken, and waits in the input register while it is held; the list
// compare and shift sit between the two registers.
// Throughput: one event per cycle while results are taken, as the compare and shift per list is combinational.
// Reset (synchronous, active high): both lists and all counters clear to zero,
// card_valid and card_type clear, and both pipeline registers empty.

module recent_id_move_to_front_counter (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_ready,
   input  wire  ridmtf_pkg::req_type                   req,
   output logic                                        rsp_valid,
   input  wire                                         rsp_ready,
   output ridmtf_pkg::rsp_type                         rsp,
   input  wire                                         csr_we,
   input  wire  [ridmtf_pkg::CsrIndexWidth-1:0]        csr_index,
   input  wire  [ridmtf_pkg::CsrDataWidth-1:0]         csr_wdata
);

   logic                     card_valid_ff;
   logic [1:0]               card_type_ff;

   logic                     in_valid_ff;
   ridmtf_pkg::req_type      in_ff;

   logic                     out_valid_ff;
   ridmtf_pkg::rsp_type      out_ff;
   ridmtf_pkg::rsp_type      out_in;

   ridmtf_pkg::list_type     battle_ff, battle_in;
   ridmtf_pkg::list_type     trade_ff, trade_in;
   ridmtf_pkg::count_type    wins_ff, wins_in;
   ridmtf_pkg::count_type    losses_ff, losses_in;
   ridmtf_pkg::count_type    trades_ff, trades_in;

   logic                     advance;
   logic                     active;
   logic                     is_trade;
   logic                     miss;
   logic                     seen;
   ridmtf_pkg::list_type     sel_list;
   ridmtf_pkg::list_type     new_list;
   logic [ridmtf_pkg::ListDepth-1:0] hit;

   // Move the input register into the result register when that one frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   assign active   = card_valid_ff && (in_ff.kind != ridmtf_pkg::KIND_UNDEF);
   assign is_trade = (in_ff.kind == ridmtf_pkg::KIND_TRADE);
   assign sel_list = is_trade ? trade_ff : battle_ff;

   // Compare all entries in parallel, then shift back everything ahead of the first hit
   always_comb begin
      for (int k = 0; k < ridmtf_pkg::ListDepth; k++) begin
         hit[k] = (sel_list[k] == in_ff.partner_id);
      end
      miss        = ~|hit;
      new_list[0] = in_ff.partner_id;
      seen        = hit[0];
      for (int k = 1; k < ridmtf_pkg::ListDepth; k++) begin
         new_list[k] = seen ? sel_list[k] : sel_list[k-1];
         seen        = seen | hit[k];
      end
   end

   // Next state of lists and counters
   always_comb begin
      battle_in = battle_ff;
      trade_in  = trade_ff;
      wins_in   = wins_ff;
      losses_in = losses_ff;
      trades_in = trades_ff;
      if (advance && active) begin
         if (is_trade) begin
            trade_in = new_list;
         end else begin
            battle_in = new_list;
         end
         if (miss && (card_type_ff == ridmtf_pkg::CountingType)) begin
            case (in_ff.kind)
               ridmtf_pkg::KIND_WIN:   wins_in   = ridmtf_pkg::sat_inc(wins_ff);
               ridmtf_pkg::KIND_LOSS:  losses_in = ridmtf_pkg::sat_inc(losses_ff);
               ridmtf_pkg::KIND_TRADE: trades_in = ridmtf_pkg::sat_inc(trades_ff);
               default: ;
            endcase
         end
      end
      out_in.ignored      = !active;
      out_in.id_was_new   = active && miss;
      out_in.wins_total   = wins_in;
      out_in.losses_total = losses_in;
      out_in.trades_total = trades_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         card_valid_ff <= 1'b0;
         card_type_ff  <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            ridmtf_pkg::CsrCardValid: card_valid_ff <= csr_wdata[0];
            ridmtf_pkg::CsrCardType:  card_type_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Hold lists and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         battle_ff <= '0;
         trade_ff  <= '0;
         wins_ff   <= '0;
         losses_ff <= '0;
         trades_ff <= '0;
      end else begin
         battle_ff <= battle_in;
         trade_ff  <= trade_in;
         wins_ff   <= wins_in;
         losses_ff <= losses_in;
         trades_ff <= trades_in;
      end
   end

   // Input register: capture on request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req;
      end
   end

   // Result register: load on advance, drop after response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ridmtf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ridmtf_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_ready,
   input wire ridmtf_pkg::req_type             req,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input wire ridmtf_pkg::rsp_type             rsp,
   input wire                                  csr_we,
   input wire [ridmtf_pkg::CsrIndexWidth-1:0]  csr_index,
   input wire [ridmtf_pkg::CsrDataWidth-1:0]   csr_wdata
);

   // An ignored event never reports a new id
   a_ignored_not_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.ignored |-> !rsp.id_was_new)
      else $error("ignored event reported a new id");

   // Counters never exceed the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.wins_total <= ridmtf_pkg::CountMax) &&
                    (rsp.losses_total <= ridmtf_pkg::CountMax) &&
                    (rsp.trades_total <= ridmtf_pkg::CountMax))
      else $error("event counter above limit");

   // No result comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

endmodule

bind recent_id_move_to_front_counter ridmtf_checker u_ridmtf_checker (.*);

`default_nettype wire
